// ===== rtl/core/htrip_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hex text image parser package
// Shared types, character codes and the hex digit decode.
// ----------------------------------------------------------------------------
package htrip_pkg;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF_HEX = 8'h66;
   localparam logic [7:0] LETTER_BASE = 8'd10;
   localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

   typedef enum logic [3:0] {
      MODE_HDR0    = 4'd0,
      MODE_HDR1    = 4'd1,
      MODE_HDR2    = 4'd2,
      MODE_HDR3    = 4'd3,
      MODE_COLON   = 4'd4,
      MODE_IDLE    = 4'd5,
      MODE_LOW     = 4'd6,
      MODE_COMMENT = 4'd7,
      MODE_FAIL    = 4'd8
   } mode_type;

   typedef struct packed {
      logic        byte_valid;
      logic [7:0]  data;
      logic [15:0] address;
      logic        done_res;
      logic        ok;
      logic [15:0] byte_count;
   } result_type;

   // Any character outside 0-9, A-F and a-f decodes as zero.
   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         v = c - CHAR_0;
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         v = c - CHAR_UA + LETTER_BASE;
      end else if (c >= CHAR_LA && c <= CHAR_LF_HEX) begin
         v = c - CHAR_LA + LETTER_BASE;
      end
      return v[3:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/htrip_parse.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hex text image parser: parse state and step logic
// Holds the parse mode, offset, pending nibble and byte count, and forms the
// result for the character held in the input register.
// ----------------------------------------------------------------------------
module htrip_parse
   import htrip_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] ch,
   input  wire logic       last,
   output logic            has_result,
   output result_type      result
);

   mode_type    mode_ff, mode_in;
   logic [3:0]  high_ff, high_in;
   logic [15:0] offset_ff, offset_in;
   logic [15:0] count_ff, count_in;

   logic [3:0]  nib;
   logic        got_byte;
   logic        is_space;

   assign nib = nibble_of(ch);
   assign is_space = (ch == CHAR_SPACE) || (ch == CHAR_TAB) ||
                     (ch == CHAR_CR) || (ch == CHAR_LF);

   always_comb begin
      mode_in   = mode_ff;
      high_in   = high_ff;
      offset_in = offset_ff;
      count_in  = count_ff;
      got_byte  = 1'b0;
      result    = '0;

      unique case (mode_ff)
         MODE_HDR0: begin
            offset_in = {offset_ff[11:0], nib};
            mode_in   = MODE_HDR1;
         end
         MODE_HDR1: begin
            offset_in = {offset_ff[11:0], nib};
            mode_in   = MODE_HDR2;
         end
         MODE_HDR2: begin
            offset_in = {offset_ff[11:0], nib};
            mode_in   = MODE_HDR3;
         end
         MODE_HDR3: begin
            offset_in = {offset_ff[11:0], nib};
            mode_in   = MODE_COLON;
         end
         MODE_COLON: begin
            mode_in = (ch == CHAR_COLON) ? MODE_IDLE : MODE_FAIL;
         end
         MODE_IDLE: begin
            if (ch == CHAR_HASH) begin
               mode_in = MODE_COMMENT;
            end else if (!is_space) begin
               high_in = nib;
               mode_in = MODE_LOW;
            end
         end
         MODE_LOW: begin
            got_byte       = 1'b1;
            result.data    = {high_ff, nib};
            result.address = offset_ff + count_ff;
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + 16'd1;
            end
            mode_in = MODE_IDLE;
         end
         MODE_COMMENT: begin
            if (ch == CHAR_LF) begin
               mode_in = MODE_IDLE;
            end
         end
         default: begin
            mode_in = MODE_FAIL;
         end
      endcase

      result.byte_valid = got_byte;
      result.done_res   = last;
      result.ok         = last && ((mode_in == MODE_IDLE) || (mode_in == MODE_LOW) ||
                                   (mode_in == MODE_COMMENT));
      result.byte_count = count_in;
      has_result        = got_byte || last;

      // The final character returns the parser to its reset state.
      if (last) begin
         mode_in   = MODE_HDR0;
         high_in   = 4'd0;
         offset_in = 16'd0;
         count_in  = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_HDR0;
         high_ff   <= 4'd0;
         offset_ff <= 16'd0;
         count_ff  <= 16'd0;
      end else if (step) begin
         mode_ff   <= mode_in;
         high_ff   <= high_in;
         offset_ff <= offset_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/htrip_out_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Hex text image parser: result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module htrip_out_reg
   import htrip_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  wire result_type  result,
   output logic             free,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_byte_valid,
   output logic [7:0]       rsp_data,
   output logic [15:0]      rsp_address,
   output logic             rsp_done_res,
   output logic             rsp_ok,
   output logic [15:0]      rsp_byte_count
);

   logic       valid_ff, valid_in;
   result_type word_ff;

   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load ? 1'b1 : (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= result;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_byte_valid = word_ff.byte_valid;
   assign rsp_data       = word_ff.data;
   assign rsp_address    = word_ff.address;
   assign rsp_done_res   = word_ff.done_res;
   assign rsp_ok         = word_ff.ok;
   assign rsp_byte_count = word_ff.byte_count;

endmodule
`default_nettype wire

// ===== rtl/core/hex_text_rom_image_parser_unit.sv =====
`default_nettype none
// An accepted character is held in the input register; when it steps, its result is loaded
// into the result register and shown on rsp_ from there until the receiver takes it.
// Throughput: one character per cycle unless stalled; a character with no result never waits.
// The input register stalls only while a result waits for a full result register.
// Synchronous reset empties both registers and returns the parser to the header state.
// ----------------------------------------------------------------------------
// Hex text image parser
// Parses a four-digit hex load offset, a colon and a body of hex byte pairs
// with whitespace and comments, giving one word per byte and a final status.
// ----------------------------------------------------------------------------
module hex_text_rom_image_parser_unit
   import htrip_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_ch,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_byte_valid,
   output logic [7:0]       rsp_data,
   output logic [15:0]      rsp_address,
   output logic             rsp_done_res,
   output logic             rsp_ok,
   output logic [15:0]      rsp_byte_count
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_ch_ff;
   logic       in_last_ff;
   logic       accept;
   logic       step;
   logic       has_result;
   logic       out_free;
   result_type result;

   // A character with no result never waits on the result register.
   assign step        = in_valid_ff && (!has_result || out_free);
   assign req_stall   = in_valid_ff && !step;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept ? 1'b1 : (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ch_ff   <= req_ch;
         in_last_ff <= req_last;
      end
   end

   htrip_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .ch         (in_ch_ff),
      .last       (in_last_ff),
      .has_result (has_result),
      .result     (result)
   );

   htrip_out_reg u_out (
      .clock          (clock),
      .reset          (reset),
      .load           (step && has_result),
      .result         (result),
      .free           (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_data       (rsp_data),
      .rsp_address    (rsp_address),
      .rsp_done_res   (rsp_done_res),
      .rsp_ok         (rsp_ok),
      .rsp_byte_count (rsp_byte_count)
   );

endmodule
`default_nettype wire
